@@ design/flpw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpw_pkg: shared types and codes for the flash log page writer
// Item kinds, event codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package flpw_pkg;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_SYNC  = 2'd2;

	localparam logic [3:0] EV_ADMIT      = 4'd0;
	localparam logic [3:0] EV_REJECT     = 4'd1;
	localparam logic [3:0] EV_STORED     = 4'd2;
	localparam logic [3:0] EV_DROPPED    = 4'd3;
	localparam logic [3:0] EV_ERASE_DONE = 4'd4;
	localparam logic [3:0] EV_PROG_DONE  = 4'd5;
	localparam logic [3:0] EV_ERASE_BUSY = 4'd6;
	localparam logic [3:0] EV_PROG_BUSY  = 4'd7;
	localparam logic [3:0] EV_IDLE       = 4'd8;

	localparam int unsigned CFG_W   = 25;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned CNT_W   = 13;
	localparam logic [CFG_W-1:0] TOTAL_RESET = 25'd2097152;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FILL,
		ST_FILL_WAIT,
		ST_EMIT,
		ST_EMIT_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MODE_ERASE   = 2'd0,
		MODE_PROGRAM = 2'd1,
		MODE_RETRY   = 2'd2,
		MODE_IDLE    = 2'd3
	} mode_t;

	typedef struct packed {
		logic latch_item;
		logic do_simple;
		logic do_erase;
		logic fill_start;
		logic fill_step;
		logic fill_write;
		logic emit_start;
		logic emit_read;
		logic emit_load;
		logic emit_next;
		logic commit;
		logic set_retry;
		logic out_valid;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       erase_cond;
		logic       prog_cond;
		logic       is_retry;
		logic       accepts;
		logic       fill_last;
		logic       emit_last;
		logic       out_taken;
	} sts_t;

endpackage

@@ design/flpw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpw_if: valid/ready channel with payload
// Generic handshake channel used for input, output and configuration.
// ----------------------------------------------------------------------------
interface flpw_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/flpw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpw_ram: single-port-write, registered-read RAM
// One write port and one read port, read data valid the cycle after.
// ----------------------------------------------------------------------------
module flpw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ design/flpw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpw_ctrl: sequencing controller
// Each item: decide, page fill (program), page emit (program, retry), output.
// ----------------------------------------------------------------------------
module flpw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  flpw_pkg::sts_t   sts,
	output flpw_pkg::cmd_t   cmd
);
	flpw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flpw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			flpw_pkg::ST_IDLE: begin
				if (in_valid) state_d = flpw_pkg::ST_DECIDE;
			end
			flpw_pkg::ST_DECIDE: begin
				if (sts.kind != flpw_pkg::KIND_SYNC || sts.erase_cond) begin
					state_d = flpw_pkg::ST_OUT;
				end else if (sts.prog_cond) begin
					state_d = flpw_pkg::ST_FILL;
				end else if (sts.is_retry) begin
					state_d = flpw_pkg::ST_EMIT;
				end else begin
					state_d = flpw_pkg::ST_OUT;
				end
			end
			flpw_pkg::ST_FILL: state_d = flpw_pkg::ST_FILL_WAIT;
			flpw_pkg::ST_FILL_WAIT: begin
				state_d = sts.fill_last ? flpw_pkg::ST_EMIT : flpw_pkg::ST_FILL;
			end
			flpw_pkg::ST_EMIT: state_d = flpw_pkg::ST_EMIT_WAIT;
			flpw_pkg::ST_EMIT_WAIT: state_d = flpw_pkg::ST_OUT;
			flpw_pkg::ST_OUT: begin
				if (sts.out_taken) begin
					if (sts.emit_last) state_d = flpw_pkg::ST_IDLE;
					else state_d = flpw_pkg::ST_EMIT;
				end
			end
			default: state_d = flpw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = (state_q == flpw_pkg::ST_IDLE);
		case (state_q)
			flpw_pkg::ST_IDLE: cmd.latch_item = in_valid;
			flpw_pkg::ST_DECIDE: begin
				if (sts.kind != flpw_pkg::KIND_SYNC) begin
					cmd.do_simple = 1'b1;
				end else if (sts.erase_cond) begin
					cmd.do_erase = 1'b1;
				end else if (sts.prog_cond) begin
					cmd.fill_start = 1'b1;
				end else if (sts.is_retry) begin
					cmd.emit_start = 1'b1;
					cmd.commit = sts.accepts;
					cmd.set_retry = !sts.accepts;
				end else begin
					cmd.do_simple = 1'b1;
				end
			end
			flpw_pkg::ST_FILL: cmd.fill_step = 1'b1;
			flpw_pkg::ST_FILL_WAIT: begin
				cmd.fill_write = 1'b1;
				cmd.emit_start = sts.fill_last;
				cmd.commit = sts.fill_last && sts.accepts;
				cmd.set_retry = sts.fill_last && !sts.accepts;
			end
			flpw_pkg::ST_EMIT: cmd.emit_read = 1'b1;
			flpw_pkg::ST_EMIT_WAIT: cmd.emit_load = 1'b1;
			flpw_pkg::ST_OUT: begin
				cmd.out_valid = 1'b1;
				cmd.emit_next = sts.out_taken;
			end
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.out_valid) else $error("ready while result pending");
	a_fill_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == flpw_pkg::ST_FILL) |=> (state_q == flpw_pkg::ST_FILL_WAIT))
		else $error("fill read not followed by write");
	a_decide_after: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_item |=> (state_q == flpw_pkg::ST_DECIDE))
		else $error("item not decided");
endmodule

@@ design/flpw_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpw_dp: byte FIFO, page buffer and log state
// Holds the FIFO memory, page store, write address and message state.
// ----------------------------------------------------------------------------
module flpw_dp #(
	parameter int unsigned FIFO_DEPTH   = 4096,
	parameter int unsigned PAGE_BYTES   = 256,
	parameter int unsigned SECTOR_BYTES = 65536,
	parameter int unsigned ADDR_BITS    = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    in_kind,
	input  logic [flpw_pkg::LEN_W-1:0]    in_len,
	input  logic [7:0]                    in_byte,
	input  logic                          in_acc,
	input  logic                          cfg_we,
	input  logic [flpw_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          out_ready,
	input  flpw_pkg::cmd_t                cmd,
	output flpw_pkg::sts_t                sts,
	output logic [3:0]                    o_event,
	output logic [23:0]                   o_addr,
	output logic [63:0]                   o_word,
	output logic                          o_last,
	output logic                          o_full,
	output logic [24:0]                   o_committed,
	output logic [12:0]                   o_count
);
	localparam int unsigned FA_W   = $clog2(FIFO_DEPTH);
	localparam int unsigned FC_W   = FA_W + 1;
	localparam int unsigned WORDS  = (PAGE_BYTES + 7) / 8;
	localparam int unsigned PW_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned PB_W   = $clog2(PAGE_BYTES + 1);
	localparam int unsigned SEC_W  = $clog2(SECTOR_BYTES);
	localparam int unsigned BI_W   = $clog2(WORDS * 8);

	logic [1:0]                 kind_q;
	logic [flpw_pkg::LEN_W-1:0] len_q;
	logic [7:0]                 byte_q;
	logic                       acc_q;
	logic [flpw_pkg::CFG_W-1:0] total_q;
	logic [FA_W-1:0]            head_q, tail_q;
	logic [FC_W-1:0]            count_q;
	logic [24:0]                waddr_q;
	flpw_pkg::mode_t            mode_q;
	logic                       erased_q, full_q, adm_q;
	logic [flpw_pkg::LEN_W-1:0] left_q;
	logic [PB_W-1:0]            fill_q;
	logic [PW_W-1:0]            word_q;
	logic [63:0]                asm_q;
	logic [3:0]                 ev_q;
	logic [23:0]                oaddr_q;
	logic [63:0]                oword_q;
	logic                       olast_q;
	logic                       prog_ev_q;
	logic [23:0]                paddr_q;

	logic                       f_we;
	logic [7:0]                 f_rdata;
	logic [FA_W-1:0]            f_raddr;
	logic [63:0]                p_rdata;
	logic                       p_we;
	logic [24:0]                space;
	logic [BI_W-1:0]            bidx;
	logic                       fill_pad;

	assign f_we = cmd.do_simple && kind_q == flpw_pkg::KIND_BYTE && adm_q
		&& left_q != '0 && count_q < FC_W'(FIFO_DEPTH);
	assign f_raddr = tail_q;
	assign bidx = fill_q[BI_W-1:0];
	assign fill_pad = 1'b0;
	assign p_we = cmd.fill_write && (bidx[2:0] == 3'd7 || fill_q == PB_W'(PAGE_BYTES - 1));

	flpw_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk, .we(f_we), .waddr(head_q), .wdata(byte_q), .raddr(f_raddr), .rdata(f_rdata)
	);

	logic [63:0] asm_next;
	always_comb begin
		asm_next = asm_q;
		asm_next[bidx[2:0]*8 +: 8] = f_rdata;
	end

	flpw_ram #(.WIDTH(64), .DEPTH(1 << PW_W)) u_page (
		.clk, .we(p_we), .waddr(bidx[BI_W-1 -: PW_W]), .wdata(asm_next),
		.raddr(word_q), .rdata(p_rdata)
	);

	assign space = (waddr_q < total_q) ? total_q - waddr_q : '0;

	assign sts.kind       = kind_q;
	assign sts.erase_cond = !erased_q && waddr_q[SEC_W-1:0] == '0;
	assign sts.prog_cond  = count_q > FC_W'(PAGE_BYTES) && mode_q != flpw_pkg::MODE_RETRY;
	assign sts.is_retry   = mode_q == flpw_pkg::MODE_RETRY;
	assign sts.accepts    = acc_q;
	assign sts.fill_last  = fill_q == PB_W'(PAGE_BYTES - 1);
	assign sts.emit_last  = word_q == PW_W'(WORDS - 1);
	assign sts.out_taken  = out_ready;

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			kind_q <= in_kind;
			len_q  <= in_len;
			byte_q <= in_byte;
			acc_q  <= in_acc;
		end
		if (cmd.fill_start) asm_q <= '0;
		else if (cmd.fill_write) asm_q <= (bidx[2:0] == 3'd7) ? '0 : asm_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= flpw_pkg::TOTAL_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			waddr_q   <= '0;
			mode_q    <= flpw_pkg::MODE_IDLE;
			erased_q  <= 1'b0;
			full_q    <= 1'b0;
			adm_q     <= 1'b0;
			left_q    <= '0;
			fill_q    <= '0;
			word_q    <= '0;
			ev_q      <= flpw_pkg::EV_IDLE;
			oaddr_q   <= '0;
			oword_q   <= '0;
			olast_q   <= 1'b0;
			prog_ev_q <= 1'b0;
			paddr_q   <= '0;
		end else begin
			if (cfg_we) total_q <= cfg_data;
			if (cmd.do_simple) begin
				olast_q <= 1'b1;
				oaddr_q <= '0;
				oword_q <= '0;
				word_q  <= PW_W'(WORDS - 1);
				case (kind_q)
					flpw_pkg::KIND_START: begin
						if (space > 25'(len_q)) begin
							full_q <= 1'b0;
							adm_q  <= len_q != '0;
							left_q <= len_q;
							ev_q   <= flpw_pkg::EV_ADMIT;
						end else begin
							full_q <= 1'b1;
							adm_q  <= 1'b0;
							left_q <= '0;
							ev_q   <= flpw_pkg::EV_REJECT;
						end
					end
					flpw_pkg::KIND_BYTE: begin
						ev_q <= flpw_pkg::EV_DROPPED;
						if (adm_q && left_q != '0) begin
							left_q <= left_q - 1'b1;
							if (left_q == 16'd1) adm_q <= 1'b0;
							if (f_we) begin
								head_q  <= head_q + 1'b1;
								count_q <= count_q + 1'b1;
								ev_q    <= flpw_pkg::EV_STORED;
							end
						end
					end
					default: ev_q <= flpw_pkg::EV_IDLE;
				endcase
			end
			if (cmd.do_erase) begin
				olast_q <= 1'b1;
				oaddr_q <= waddr_q[23:0] & 24'((64'd1 << ADDR_BITS) - 1);
				oword_q <= '0;
				word_q  <= PW_W'(WORDS - 1);
				if (acc_q) begin
					erased_q <= 1'b1;
					mode_q   <= flpw_pkg::MODE_IDLE;
					ev_q     <= flpw_pkg::EV_ERASE_DONE;
				end else begin
					mode_q   <= flpw_pkg::MODE_ERASE;
					ev_q     <= flpw_pkg::EV_ERASE_BUSY;
				end
			end
			if (cmd.fill_start) fill_q <= '0;
			if (cmd.fill_step) begin
				tail_q  <= tail_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (cmd.fill_write && !sts.fill_last) fill_q <= fill_q + 1'b1;
			if (cmd.emit_start) begin
				word_q    <= '0;
				prog_ev_q <= acc_q;
				paddr_q   <= waddr_q[23:0] & 24'((64'd1 << ADDR_BITS) - 1);
			end
			if (cmd.emit_load) begin
				ev_q    <= prog_ev_q ? flpw_pkg::EV_PROG_DONE : flpw_pkg::EV_PROG_BUSY;
				oaddr_q <= paddr_q;
				oword_q <= p_rdata;
				olast_q <= sts.emit_last;
			end
			if (cmd.commit) begin
				waddr_q  <= waddr_q + 25'(PAGE_BYTES);
				erased_q <= 1'b0;
				mode_q   <= flpw_pkg::MODE_IDLE;
			end
			if (cmd.set_retry) mode_q <= flpw_pkg::MODE_RETRY;
			if (cmd.emit_next && !sts.emit_last) word_q <= word_q + 1'b1;
		end
	end

	assign o_event     = ev_q;
	assign o_addr      = oaddr_q;
	assign o_word      = oword_q | {63'd0, fill_pad};
	assign o_last      = olast_q;
	assign o_full      = full_q;
	assign o_committed = waddr_q;
	assign o_count     = 13'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FC_W'(FIFO_DEPTH)) else $error("fifo count overflow");
	a_fill_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> count_q != '0) else $error("pop from empty fifo");
	a_commit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> mode_q == flpw_pkg::MODE_IDLE) else $error("commit left mode");
endmodule

@@ design/flash_log_page_writer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_log_page_writer_core: FIFO-buffered flash log page writer
// Queues log bytes and commits them to serial flash in pages.
// Write start, byte, idle and erase items pass through decide to one result beat.
// Program sync: the page is filled byte by byte through the FIFO RAM read port,
// then emitted word by word as result beats; a retry sync re-emits the stored page.
// A new item is taken only once the previous item's last result beat is accepted.
// Reset: arst_n clears all control state; FIFO and page RAMs are not cleared.
// ----------------------------------------------------------------------------
module flash_log_page_writer_core #(
	parameter int unsigned FIFO_DEPTH   = 4096,
	parameter int unsigned PAGE_BYTES   = 256,
	parameter int unsigned SECTOR_BYTES = 65536,
	parameter int unsigned ADDR_BITS    = 24
) (
	input logic clk,
	input logic arst_n,
	flpw_if.sink   in_ch,
	flpw_if.sink   cfg,
	flpw_if.source out_ch
);
	flpw_pkg::cmd_t cmd;
	flpw_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	flpw_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .sts, .cmd
	);

	flpw_dp #(
		.FIFO_DEPTH(FIFO_DEPTH), .PAGE_BYTES(PAGE_BYTES),
		.SECTOR_BYTES(SECTOR_BYTES), .ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk, .arst_n,
		.in_kind(in_ch.payload.kind),
		.in_len(in_ch.payload.message_length),
		.in_byte(in_ch.payload.data_byte),
		.in_acc(in_ch.payload.flash_accepts),
		.cfg_we(cfg.valid),
		.cfg_data(cfg.payload),
		.out_ready(out_ch.ready),
		.cmd, .sts,
		.o_event(out_ch.payload.event_res),
		.o_addr(out_ch.payload.flash_address),
		.o_word(out_ch.payload.page_word),
		.o_last(out_ch.payload.last),
		.o_full(out_ch.payload.log_full),
		.o_committed(out_ch.payload.bytes_committed),
		.o_count(out_ch.payload.buffered_count)
	);

	assign out_ch.valid = cmd.out_valid;
endmodule

@@ dv/flpw_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpw_tb_pkg: beat layouts for the flash log page writer testbench
// Packed payloads of the item, result and configuration channels.
// ----------------------------------------------------------------------------
package flpw_tb_pkg;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] message_length;
		logic [7:0]  data_byte;
		logic        flash_accepts;
	} log_item_t;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [23:0] flash_address;
		logic [63:0] page_word;
		logic        last;
		logic        log_full;
		logic [24:0] bytes_committed;
		logic [12:0] buffered_count;
	} log_result_t;

	typedef logic [24:0] total_word_t;

endpackage

@@ dv/flpw_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpw_scoreboard: result predictor and checker for the page writer
// Watches the item, result and configuration channels, keeps its own copy of
// the FIFO, page buffer and flash write state, and compares every result beat
// field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module flpw_scoreboard (
	input  logic clk,
	input  logic arst_n,
	flpw_if      in_ch,
	flpw_if      cfg,
	flpw_if      out_ch,
	output int   fail_count,
	output int   pending
);

	localparam int DEPTH  = 4096;
	localparam int PAGE   = 256;
	localparam int PWORDS = (PAGE + 7) / 8;

	logic [7:0]  fifo_mem [DEPTH];
	logic [7:0]  page_img [PWORDS*8];
	logic [11:0] head, tail;
	logic [12:0] count;
	logic [24:0] waddr;
	logic [24:0] total;
	flpw_pkg::mode_t mode;
	logic        erased, full, admitted;
	logic [15:0] left;
	flpw_tb_pkg::log_result_t expected_q[$];
	flpw_tb_pkg::log_result_t burst[$];
	int          fails;

	assign fail_count = fails;
	assign pending    = expected_q.size();

	function automatic flpw_tb_pkg::log_result_t make_beat(logic [3:0] ev,
			logic [24:0] addr, logic [63:0] word);
		flpw_tb_pkg::log_result_t r;
		r.event_res       = ev;
		r.flash_address   = addr[23:0];
		r.page_word       = word;
		r.last            = 1'b0;
		r.log_full        = full;
		r.bytes_committed = waddr;
		r.buffered_count  = count;
		return r;
	endfunction

	task automatic page_beats(logic [3:0] ev, logic [24:0] addr);
		logic [63:0] w;
		for (int k = 0; k < PWORDS; k++) begin
			for (int b = 0; b < 8; b++)
				w[8*b +: 8] = page_img[8*k + b];
			burst.push_back(make_beat(ev, addr, w));
		end
	endtask

	task automatic predict_item(flpw_tb_pkg::log_item_t it);
		logic [25:0] space;
		logic [24:0] old;
		burst.delete();
		case (it.kind)
			flpw_pkg::KIND_START: begin
				space = (waddr < total) ? {1'b0, total} - {1'b0, waddr} : 26'd0;
				if (space > {10'd0, it.message_length}) begin
					full     = 1'b0;
					admitted = it.message_length != 0;
					left     = it.message_length;
					burst.push_back(make_beat(flpw_pkg::EV_ADMIT, 0, 0));
				end else begin
					full     = 1'b1;
					admitted = 1'b0;
					left     = 0;
					burst.push_back(make_beat(flpw_pkg::EV_REJECT, 0, 0));
				end
			end
			flpw_pkg::KIND_BYTE: begin
				logic [3:0] ev;
				ev = flpw_pkg::EV_DROPPED;
				if (admitted && left > 0) begin
					left--;
					if (left == 0)
						admitted = 1'b0;
					if (count < DEPTH) begin
						fifo_mem[head] = it.data_byte;
						head++;
						count++;
						ev = flpw_pkg::EV_STORED;
					end
				end
				burst.push_back(make_beat(ev, 0, 0));
			end
			flpw_pkg::KIND_SYNC: begin
				if (!erased && waddr[15:0] == 0)
					mode = flpw_pkg::MODE_ERASE;
				else if (count > PAGE && mode != flpw_pkg::MODE_RETRY)
					mode = flpw_pkg::MODE_PROGRAM;
				if (mode == flpw_pkg::MODE_ERASE) begin
					if (it.flash_accepts) begin
						erased = 1'b1;
						mode   = flpw_pkg::MODE_IDLE;
						burst.push_back(make_beat(flpw_pkg::EV_ERASE_DONE, waddr, 0));
					end else
						burst.push_back(make_beat(flpw_pkg::EV_ERASE_BUSY, waddr, 0));
				end else if (mode == flpw_pkg::MODE_PROGRAM || mode == flpw_pkg::MODE_RETRY) begin
					if (mode == flpw_pkg::MODE_PROGRAM) begin
						for (int i = 0; i < PWORDS*8; i++)
							page_img[i] = 8'd0;
						for (int i = 0; i < PAGE; i++) begin
							page_img[i] = fifo_mem[tail];
							tail++;
							count--;
						end
					end
					if (it.flash_accepts) begin
						old    = waddr;
						waddr  = waddr + 25'(PAGE);
						erased = 1'b0;
						mode   = flpw_pkg::MODE_IDLE;
						page_beats(flpw_pkg::EV_PROG_DONE, old);
					end else begin
						mode = flpw_pkg::MODE_RETRY;
						page_beats(flpw_pkg::EV_PROG_BUSY, waddr);
					end
				end else
					burst.push_back(make_beat(flpw_pkg::EV_IDLE, 0, 0));
			end
			default: burst.push_back(make_beat(flpw_pkg::EV_IDLE, 0, 0));
		endcase
		burst[burst.size()-1].last = 1'b1;
		foreach (burst[i])
			expected_q.push_back(burst[i]);
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	task automatic compare_beat(flpw_tb_pkg::log_result_t got);
		flpw_tb_pkg::log_result_t want;
		if (expected_q.size() == 0) begin
			report("unexpected beat", got.event_res, 0);
			return;
		end
		want = expected_q.pop_front();
		if (got.event_res != want.event_res)
			report("event_res", got.event_res, want.event_res);
		if (got.flash_address != want.flash_address)
			report("flash_address", got.flash_address, want.flash_address);
		if (got.page_word != want.page_word)
			report("page_word", got.page_word, want.page_word);
		if (got.last != want.last)
			report("last", got.last, want.last);
		if (got.log_full != want.log_full)
			report("log_full", got.log_full, want.log_full);
		if (got.bytes_committed != want.bytes_committed)
			report("bytes_committed", got.bytes_committed, want.bytes_committed);
		if (got.buffered_count != want.buffered_count)
			report("buffered_count", got.buffered_count, want.buffered_count);
	endtask

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head     = 0;
			tail     = 0;
			count    = 0;
			waddr    = 0;
			total    = flpw_pkg::TOTAL_RESET;
			mode     = flpw_pkg::MODE_IDLE;
			erased   = 1'b0;
			full     = 1'b0;
			admitted = 1'b0;
			left     = 0;
			expected_q.delete();
		end else begin
			if (out_ch.valid && out_ch.ready)
				compare_beat(out_ch.payload);
			if (cfg.valid && cfg.ready)
				total = cfg.payload;
			if (in_ch.valid && in_ch.ready)
				predict_item(in_ch.payload);
		end
	end

endmodule

@@ dv/flash_log_page_writer_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_log_page_writer_core_test: top of the page writer testbench
// Drives directed and random log traffic with random idling on both sides,
// a long result stall, a program and retry pass and several capacity
// settings, then reports the verdict from the scoreboard.
// ----------------------------------------------------------------------------
module flash_log_page_writer_core_test;

	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   out_beats = 0;
	int   stall_cycles = 0;
	bit   quiet;
	bit   long_hold_done = 0;

	flpw_if #(.payload_t(flpw_tb_pkg::log_item_t))   in_ch ();
	flpw_if #(.payload_t(flpw_tb_pkg::total_word_t)) cfg ();
	flpw_if #(.payload_t(flpw_tb_pkg::log_result_t)) out_ch ();

	flash_log_page_writer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.out_ch (out_ch)
	);

	flpw_scoreboard checker_u (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		cfg.valid     = 1'b0;
		cfg.payload   = '0;
		out_ch.ready  = 1'b0;
		arst_n        = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			out_beats <= out_beats + 1;
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL flash_log_page_writer_core");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && out_beats >= 60) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				long_hold_done = 1;
				out_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else
				out_ch.ready <= 1'b1;
		end
	end

	task automatic send_item(logic [1:0] kind, logic [15:0] len, logic [7:0] data,
			logic acc);
		flpw_tb_pkg::log_item_t it;
		it.kind           = kind;
		it.message_length = len;
		it.data_byte      = data;
		it.flash_accepts  = acc;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= it;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	task automatic drain_items();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait (pending == 0);
	endtask

	task automatic write_total(flpw_tb_pkg::total_word_t value);
		drain_items();
		repeat (20) @(negedge clk);
		cfg.valid   <= 1'b1;
		cfg.payload <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_sync();
		send_item(flpw_pkg::KIND_SYNC, 16'($urandom), 8'($urandom),
			$urandom_range(0, 3) != 0);
	endtask

	task automatic run_messages(int n, int sync_pct);
		int sent;
		int len;
		int nb;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 85) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(1, 40);
				send_item(flpw_pkg::KIND_START, 16'(len), 8'($urandom), 1'($urandom));
				nb = (len > 40) ? 40 : len;
				if ($urandom_range(0, 3) == 0)
					nb += $urandom_range(1, 3);
				sent++;
				for (int i = 0; i < nb && sent < n; i++) begin
					if ($urandom_range(0, 99) < sync_pct) begin
						send_sync();
						sent++;
					end
					send_item(flpw_pkg::KIND_BYTE, 16'($urandom), 8'($urandom),
						1'($urandom));
					sent++;
				end
			end else begin
				send_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
					1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		quiet = 0;
		@(posedge arst_n);

		send_item(flpw_pkg::KIND_SYNC, 16'h0000, 8'h00, 1'b0);
		send_item(flpw_pkg::KIND_SYNC, 16'hFFFF, 8'hFF, 1'b1);
		send_item(flpw_pkg::KIND_SYNC, 16'h0000, 8'h00, 1'b1);
		send_item(2'd3, 16'hFFFF, 8'hFF, 1'b1);
		send_item(flpw_pkg::KIND_START, 16'h0000, 8'h00, 1'b0);
		send_item(flpw_pkg::KIND_BYTE, 16'h0000, 8'hAA, 1'b0);
		send_item(flpw_pkg::KIND_START, 16'hFFFF, 8'h00, 1'b0);
		send_item(flpw_pkg::KIND_BYTE, 16'hFFFF, 8'h00, 1'b1);
		send_item(flpw_pkg::KIND_BYTE, 16'h0000, 8'hFF, 1'b0);
		send_item(flpw_pkg::KIND_SYNC, 16'h0000, 8'h00, 1'b0);
		write_total('0);
		send_item(flpw_pkg::KIND_START, 16'h0000, 8'h00, 1'b0);
		send_item(flpw_pkg::KIND_BYTE, 16'h0000, 8'h55, 1'b0);
		write_total(25'h1000000);
		send_item(flpw_pkg::KIND_START, 16'hFFFF, 8'h00, 1'b0);
		send_item(flpw_pkg::KIND_BYTE, 16'h0000, 8'h12, 1'b0);

		send_item(flpw_pkg::KIND_START, 16'd260, 8'h00, 1'b0);
		for (int i = 0; i < 260; i++)
			send_item(flpw_pkg::KIND_BYTE, 16'($urandom), 8'($urandom), 1'($urandom));
		send_item(flpw_pkg::KIND_SYNC, 16'h0000, 8'h00, 1'b0);
		send_item(flpw_pkg::KIND_SYNC, 16'h0000, 8'h00, 1'b0);
		send_item(flpw_pkg::KIND_SYNC, 16'h0000, 8'h00, 1'b1);

		run_messages(50, 6);

		write_total(25'd600);
		run_messages(30, 8);
		send_item(flpw_pkg::KIND_START, 16'h0000, 8'h00, 1'b0);

		write_total(flpw_pkg::TOTAL_RESET);
		quiet = 1;
		run_messages(60, 8);
		repeat (10)
			send_sync();

		drain_items();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("PASS flash_log_page_writer_core");
		else
			$display("FAIL flash_log_page_writer_core");
		$finish;
	end

endmodule
